>>> design/fsbc_pkg.sv
`timescale 1ns / 1ps

package fsbc_pkg;

  localparam int unsigned NUM_PLANES  = 6;
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned INDEX_WIDTH = 3;
  localparam int unsigned MODE_WIDTH  = 2;
  // offsets and radii are Q16.16, products Q32.32
  localparam int unsigned FRAC_BITS   = 16;

  typedef logic [MODE_WIDTH-1:0] mode_t;

  localparam mode_t MODE_LOAD   = 2'd0;
  localparam mode_t MODE_SPHERE = 2'd1;
  localparam mode_t MODE_BOX    = 2'd2;

  typedef logic signed [FIELD_WIDTH-1:0] field_t;

  // request travelling down the plane chain
  typedef struct packed {
    mode_t                  mode;
    logic [INDEX_WIDTH-1:0] plane_index;
    field_t                 vec_a_x;
    field_t                 vec_a_y;
    field_t                 vec_a_z;
    field_t                 vec_b_x;
    field_t                 vec_b_y;
    field_t                 vec_b_z;
    field_t                 scalar;
    logic                   culled;
  } item_t;

endpackage

>>> design/fsbc_if.sv
`timescale 1ns / 1ps

interface fsbc_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [fsbc_pkg::MODE_WIDTH-1:0]        mode;
  logic [fsbc_pkg::INDEX_WIDTH-1:0]       plane_index;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] vec_a_x;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] vec_a_y;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] vec_a_z;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] vec_b_x;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] vec_b_y;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] vec_b_z;
  logic signed [fsbc_pkg::FIELD_WIDTH-1:0] scalar;

  modport source (
    output valid, mode, plane_index, vec_a_x, vec_a_y, vec_a_z,
           vec_b_x, vec_b_y, vec_b_z, scalar,
    input  ready
  );
  modport sink (
    input  valid, mode, plane_index, vec_a_x, vec_a_y, vec_a_z,
           vec_b_x, vec_b_y, vec_b_z, scalar,
    output ready
  );
endinterface

interface fsbc_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

>>> design/fsbc_cell.sv
`timescale 1ns / 1ps

module fsbc_cell #(
  parameter int unsigned CoordWidth = fsbc_pkg::COORD_WIDTH,
  parameter int unsigned CellIdx    = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            valid_i,
  input  fsbc_pkg::item_t item_i,
  output logic            valid_o,
  output fsbc_pkg::item_t item_o
);
  import fsbc_pkg::*;

  localparam int unsigned ProdW = 2 * CoordWidth;
  localparam int unsigned AccW  = ProdW + 3;
  localparam int unsigned OffW  = CoordWidth + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ProdW-1:0]      prod_t;
  typedef logic signed [AccW-1:0]       acc_t;

  // plane held by this cell
  coord_t nx_q, ny_q, nz_q, d_q;

  logic  valid_q;
  item_t item_q;
  prod_t pax_q, pay_q, paz_q, pbx_q, pby_q, pbz_q;
  logic signed [OffW-1:0] off_q;

  coord_t ax, ay, az, bx, by, bz, sc;
  prod_t  pax_d, pay_d, paz_d, pbx_d, pby_d, pbz_d;
  logic signed [OffW-1:0] off_d;
  logic   is_load;

  assign ax = $signed(item_i.vec_a_x[CoordWidth-1:0]);
  assign ay = $signed(item_i.vec_a_y[CoordWidth-1:0]);
  assign az = $signed(item_i.vec_a_z[CoordWidth-1:0]);
  assign bx = $signed(item_i.vec_b_x[CoordWidth-1:0]);
  assign by = $signed(item_i.vec_b_y[CoordWidth-1:0]);
  assign bz = $signed(item_i.vec_b_z[CoordWidth-1:0]);
  assign sc = $signed(item_i.scalar[CoordWidth-1:0]);

  assign is_load = valid_i && (item_i.mode == MODE_LOAD)
                && (item_i.plane_index == INDEX_WIDTH'(CellIdx));

  always_comb begin
    pax_d = prod_t'(nx_q) * prod_t'(ax);
    pay_d = prod_t'(ny_q) * prod_t'(ay);
    paz_d = prod_t'(nz_q) * prod_t'(az);
    pbx_d = prod_t'(nx_q) * prod_t'(bx);
    pby_d = prod_t'(ny_q) * prod_t'(by);
    pbz_d = prod_t'(nz_q) * prod_t'(bz);
    // sphere folds the radius into the offset
    if (item_i.mode == MODE_SPHERE) begin
      off_d = {d_q[CoordWidth-1], d_q} + {sc[CoordWidth-1], sc};
    end else begin
      off_d = {d_q[CoordWidth-1], d_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      nx_q    <= '0;
      ny_q    <= '0;
      nz_q    <= '0;
      d_q     <= '0;
    end else if (advance_i) begin
      valid_q <= valid_i;
      if (is_load) begin
        nx_q <= ax;
        ny_q <= ay;
        nz_q <= az;
        d_q  <= sc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_i;
      pax_q  <= pax_d;
      pay_q  <= pay_d;
      paz_q  <= paz_d;
      pbx_q  <= pbx_d;
      pby_q  <= pby_d;
      pbz_q  <= pbz_d;
      off_q  <= off_d;
    end
  end

  // box: the corner farthest along the normal takes the larger product per axis
  prod_t tx, ty, tz;
  acc_t  sum;
  logic  is_box, is_test, behind;

  assign is_box  = (item_q.mode == MODE_BOX);
  assign is_test = is_box || (item_q.mode == MODE_SPHERE);

  always_comb begin
    tx = pax_q;
    ty = pay_q;
    tz = paz_q;
    if (is_box) begin
      if (pbx_q > pax_q) tx = pbx_q;
      if (pby_q > pay_q) ty = pby_q;
      if (pbz_q > paz_q) tz = pbz_q;
    end
    sum = {{(AccW-ProdW){tx[ProdW-1]}}, tx}
        + {{(AccW-ProdW){ty[ProdW-1]}}, ty}
        + {{(AccW-ProdW){tz[ProdW-1]}}, tz}
        + ({{(AccW-OffW){off_q[OffW-1]}}, off_q} << FRAC_BITS);
    behind = sum[AccW-1] || (sum == '0);
  end

  always_comb begin
    item_o        = item_q;
    item_o.culled = item_q.culled | (is_test & behind);
  end

  assign valid_o = valid_q;

endmodule

>>> design/frustum_sphere_box_cull_core.sv
`timescale 1ns / 1ps
// Pipeline: NUM_PLANES cell registers plus the output register.
// Throughput: one request per cycle, unless backpressure on the result stalls the chain.
// Loads travel the chain as requests and write their plane at the matching cell.
// Backpressure on the result stalls the whole chain.
// Reset: asynchronous, active low; clears all planes to zero and empties the chain.

module frustum_sphere_box_cull_core #(
  parameter int unsigned NumPlanes  = fsbc_pkg::NUM_PLANES,
  parameter int unsigned CoordWidth = fsbc_pkg::COORD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsbc_req_if.sink   req_i,
  fsbc_res_if.source res_o
);
  import fsbc_pkg::*;

  logic  chain_valid [NumPlanes+1];
  item_t chain_item  [NumPlanes+1];
  logic  advance;
  logic  out_valid_q, visible_q;

  assign advance = !out_valid_q || res_o.ready;
  assign req_i.ready = advance;

  assign chain_valid[0]             = req_i.valid;
  assign chain_item[0].mode         = req_i.mode;
  assign chain_item[0].plane_index  = req_i.plane_index;
  assign chain_item[0].vec_a_x      = req_i.vec_a_x;
  assign chain_item[0].vec_a_y      = req_i.vec_a_y;
  assign chain_item[0].vec_a_z      = req_i.vec_a_z;
  assign chain_item[0].vec_b_x      = req_i.vec_b_x;
  assign chain_item[0].vec_b_y      = req_i.vec_b_y;
  assign chain_item[0].vec_b_z      = req_i.vec_b_z;
  assign chain_item[0].scalar       = req_i.scalar;
  assign chain_item[0].culled       = 1'b0;

  for (genvar k = 0; k < NumPlanes; k++) begin : g_cell
    fsbc_cell #(
      .CoordWidth (CoordWidth),
      .CellIdx    (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (chain_valid[k]),
      .item_i    (chain_item[k]),
      .valid_o   (chain_valid[k+1]),
      .item_o    (chain_item[k+1])
    );
  end

  logic tail_test;
  assign tail_test = chain_valid[NumPlanes]
                  && ((chain_item[NumPlanes].mode == MODE_SPHERE)
                   || (chain_item[NumPlanes].mode == MODE_BOX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= tail_test;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      visible_q <= !chain_item[NumPlanes].culled;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.visible = visible_q;

endmodule

>>> design/fsbc_checker.sv
`timescale 1ns / 1ps

module fsbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_visible_i
);

  // chain moves exactly when the result register is free or drained
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!res_valid_i || res_ready_i))
    else $error("request ready does not track result register");

  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_visible_i))
    else $error("stalled result changed");

  a_empty_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !res_valid_i)
    else $error("result valid straight after reset");

  // a result can only be new if the chain advanced on the previous edge
  a_res_needs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |=> !res_valid_i || $past(req_ready_i))
    else $error("result appeared without chain advance");

endmodule

bind frustum_sphere_box_cull_core fsbc_checker u_fsbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_visible_i (res_o.visible)
);

>>> tb/frustum_sphere_box_cull_core_tb.sv
`timescale 1ns / 1ps

module frustum_sphere_box_cull_core_tb;
  import fsbc_pkg::*;

  localparam int unsigned LATENCY     = NUM_PLANES + 1;
  localparam int unsigned RAND_ITEMS  = 400;
  localparam int unsigned TAIL_ITEMS  = 60;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned NUM_CORNERS = 8;

  localparam mode_t MODE_UNUSED = 2'd3;

  localparam field_t Q_ONE     = 32'sh0001_0000;
  localparam field_t Q_NEG_ONE = 32'shFFFF_0000;
  localparam field_t Q_TEN     = 32'sh000A_0000;
  localparam field_t Q_ELEVEN  = 32'sh000B_0000;
  localparam field_t Q_TWELVE  = 32'sh000C_0000;
  localparam field_t Q_TWENTY  = 32'sh0014_0000;
  localparam field_t Q_MAX     = 32'sh7FFF_FFFF;
  localparam field_t Q_MIN     = 32'sh8000_0000;
  localparam field_t Q_NEG_ULP = 32'shFFFF_FFFF;

  typedef struct {
    mode_t                  mode;
    logic [INDEX_WIDTH-1:0] slot;
    field_t                 ax, ay, az;
    field_t                 bx, by, bz;
    field_t                 s;
  } request_t;

  typedef enum logic [1:0] {FROM_MODEL, KNOWN_VISIBLE, KNOWN_CULLED} row_check_e;

  typedef struct {
    request_t   req;
    row_check_e chk;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  fsbc_req_if req_bus ();
  fsbc_res_if res_bus ();

  frustum_sphere_box_cull_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // own copy of the plane store, cleared as at reset
  field_t plane_nx [NUM_PLANES] = '{default: '0};
  field_t plane_ny [NUM_PLANES] = '{default: '0};
  field_t plane_nz [NUM_PLANES] = '{default: '0};
  field_t plane_d  [NUM_PLANES] = '{default: '0};

  bit visible_due [$];
  int fail_count    = 0;
  int sent          = 0;
  bit bursts_on     = 1'b1;
  bit tail          = 1'b0;
  bit hold_results  = 1'b0;
  bit pressure_done = 1'b0;
  bit drain_done    = 1'b0;

  dir_row_t dir_rows [25] = '{
    // empty planes after reset
    '{'{MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, 0}, KNOWN_CULLED},
    '{'{MODE_SPHERE, 3'd7, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, KNOWN_VISIBLE},
    '{'{MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, Q_MIN}, KNOWN_CULLED},
    '{'{MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, Q_NEG_ULP}, KNOWN_CULLED},
    '{'{MODE_BOX, 3'd0, 0, 0, 0, 0, 0, 0, 0}, KNOWN_CULLED},
    '{'{MODE_BOX, 3'd5, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX}, KNOWN_CULLED},
    '{'{MODE_UNUSED, 3'd7, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, FROM_MODEL},
    // slots past the store are dropped
    '{'{MODE_LOAD, 3'd6, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd7, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, 0}, KNOWN_CULLED},
    // cube of half width ten around the origin
    '{'{MODE_LOAD, 3'd0, Q_NEG_ONE, 0, 0, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd1, Q_ONE, 0, 0, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd2, 0, Q_ONE, 0, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd3, 0, Q_NEG_ONE, 0, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd4, 0, 0, Q_NEG_ONE, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd5, 0, 0, Q_ONE, 0, 0, 0, Q_TEN}, FROM_MODEL},
    '{'{MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, Q_ONE}, FROM_MODEL},
    '{'{MODE_SPHERE, 3'd0, Q_TWELVE, 0, 0, 0, 0, 0, Q_ONE}, FROM_MODEL},
    '{'{MODE_SPHERE, 3'd0, Q_ELEVEN, 0, 0, 0, 0, 0, Q_ONE}, FROM_MODEL},
    '{'{MODE_SPHERE, 3'd0, 0, 0, 0, 0, 0, 0, Q_NEG_ONE}, FROM_MODEL},
    '{'{MODE_BOX, 3'd0, Q_TWELVE, Q_ONE, Q_ONE, Q_ELEVEN, Q_NEG_ONE, Q_NEG_ONE, 0},
      FROM_MODEL},
    // max and min given the wrong way round
    '{'{MODE_BOX, 3'd0, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE, 0},
      FROM_MODEL},
    '{'{MODE_BOX, 3'd0, Q_TWENTY, Q_ONE, Q_ONE, Q_TEN, 0, 0, 0}, FROM_MODEL},
    '{'{MODE_LOAD, 3'd0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, Q_MAX}, FROM_MODEL},
    '{'{MODE_BOX, 3'd0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0}, FROM_MODEL}
  };

  function automatic logic signed [127:0] wide(field_t v);
    logic signed [127:0] w;
    w = v;
    return w;
  endfunction

  // distance of the point to plane p, plus margin, is at most zero
  function automatic bit at_or_behind(int p, field_t px, field_t py, field_t pz,
                                      field_t margin);
    logic signed [127:0] signed_dist;
    signed_dist = wide(plane_nx[p]) * wide(px) + wide(plane_ny[p]) * wide(py)
                + wide(plane_nz[p]) * wide(pz) + (wide(plane_d[p]) <<< FRAC_BITS)
                + (wide(margin) <<< FRAC_BITS);
    return signed_dist <= 128'sd0;
  endfunction

  function automatic bit frustum_visible(request_t r);
    bit hidden;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (r.mode == MODE_SPHERE) begin
        if (at_or_behind(p, r.ax, r.ay, r.az, r.s)) return 1'b0;
      end else begin
        hidden = 1'b1;
        for (int c = 0; c < NUM_CORNERS; c++) begin
          if (!at_or_behind(p, (c & 1) ? r.bx : r.ax, (c & 2) ? r.by : r.ay,
                            (c & 4) ? r.bz : r.az, '0))
            hidden = 1'b0;
        end
        if (hidden) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void record_request(request_t r);
    case (r.mode)
      MODE_LOAD: begin
        if (r.slot < NUM_PLANES) begin
          plane_nx[r.slot] = r.ax;
          plane_ny[r.slot] = r.ay;
          plane_nz[r.slot] = r.az;
          plane_d[r.slot]  = r.s;
        end
      end
      MODE_SPHERE, MODE_BOX: visible_due.push_back(frustum_visible(r));
      default: ;
    endcase
  endfunction

  // uniform in [-units, +units] Q16.16
  function automatic field_t small_q(int unsigned units);
    int unsigned span;
    span = units << FRAC_BITS;
    return field_t'($urandom_range(0, 2 * span)) - field_t'(span);
  endfunction

  function automatic field_t rand_coord();
    case ($urandom_range(0, 9))
      0: return field_t'($urandom());
      1: begin
        case ($urandom_range(0, 3))
          0:       return Q_MIN;
          1:       return Q_MAX;
          2:       return '0;
          default: return Q_NEG_ULP;
        endcase
      end
      default: return small_q(32);
    endcase
  endfunction

  function automatic request_t random_load();
    request_t r;
    r.mode = MODE_LOAD;
    r.slot = INDEX_WIDTH'($urandom_range(0, 7));
    r.ax   = rand_coord();
    r.ay   = rand_coord();
    r.az   = rand_coord();
    r.bx   = field_t'($urandom());
    r.by   = field_t'($urandom());
    r.bz   = field_t'($urandom());
    r.s    = rand_coord();
    return r;
  endfunction

  function automatic request_t random_test();
    request_t r;
    field_t   hi [3];
    field_t   lo [3];
    field_t   centre;
    field_t   half;
    int       pick;
    r      = random_load();
    pick   = $urandom_range(0, 19);
    r.slot = INDEX_WIDTH'($urandom_range(0, 7));
    if (pick == 0) begin
      r.mode = MODE_UNUSED;
    end else if (pick < 10) begin
      r.mode = MODE_SPHERE;
      case ($urandom_range(0, 9))
        0, 1:    r.s = -field_t'($urandom_range(0, 32'h0004_0000));
        2:       r.s = rand_coord();
        default: r.s = field_t'($urandom_range(0, 32'h0008_0000));
      endcase
    end else begin
      r.mode = MODE_BOX;
      for (int i = 0; i < 3; i++) begin
        centre = rand_coord();
        half   = field_t'($urandom_range(0, 32'h0004_0000));
        hi[i]  = centre + half;
        lo[i]  = centre - half;
        if ($urandom_range(0, 4) == 0) begin
          hi[i] = centre - half;
          lo[i] = centre + half;
        end
      end
      r.ax = hi[0];
      r.ay = hi[1];
      r.az = hi[2];
      r.bx = lo[0];
      r.by = lo[1];
      r.bz = lo[2];
    end
    return r;
  endfunction

  task automatic send_req(input request_t r);
    req_bus.valid       <= 1'b1;
    req_bus.mode        <= r.mode;
    req_bus.plane_index <= r.slot;
    req_bus.vec_a_x     <= r.ax;
    req_bus.vec_a_y     <= r.ay;
    req_bus.vec_a_z     <= r.az;
    req_bus.vec_b_x     <= r.bx;
    req_bus.vec_b_y     <= r.by;
    req_bus.vec_b_z     <= r.bz;
    req_bus.scalar      <= r.s;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic issue(input request_t r, input row_check_e chk, input bit gaps);
    send_req(r);
    if (chk == FROM_MODEL) record_request(r);
    else visible_due.push_back(chk == KNOWN_VISIBLE);
    if (r.mode != MODE_UNUSED && !(r.mode == MODE_LOAD && r.slot >= NUM_PLANES))
      sent++;
    if (gaps && bursts_on && !tail && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // six planes roughly along the axes, boxing in some region near the origin
  task automatic load_frustum();
    int       slots [$];
    request_t r;
    field_t   unit;
    slots = {0, 1, 2, 3, 4, 5};
    slots.shuffle();
    foreach (slots[k]) begin
      r      = random_load();
      r.slot = INDEX_WIDTH'(slots[k]);
      r.ax   = small_q(0) + field_t'($urandom_range(0, 32'h8000)) - 32'sh4000;
      r.ay   = field_t'($urandom_range(0, 32'h8000)) - 32'sh4000;
      r.az   = field_t'($urandom_range(0, 32'h8000)) - 32'sh4000;
      unit   = (slots[k] % 2 == 0) ? Q_NEG_ONE : Q_ONE;
      case (slots[k] / 2)
        0:       r.ax = r.ax + unit;
        1:       r.ay = r.ay + unit;
        default: r.az = r.az + unit;
      endcase
      r.s = field_t'($urandom_range(32'h0001_0000, 32'h0014_0000));
      issue(r, FROM_MODEL, 1'b1);
    end
  endtask

  task automatic run_episode();
    if ($urandom_range(0, 9) < 7) load_frustum();
    else repeat ($urandom_range(1, 3)) issue(random_load(), FROM_MODEL, 1'b1);
    repeat ($urandom_range(8, 20)) issue(random_test(), FROM_MODEL, 1'b1);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_results) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (bursts_on && !tail && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        res_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    logic want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (visible_due.size() == 0) begin
        $error("visible: expected no result, got %0b", res_bus.visible);
        fail_count++;
      end else begin
        want = visible_due.pop_front();
        if (res_bus.visible !== want) begin
          $error("visible: expected %0b, got %0b", want, res_bus.visible);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.mode        = MODE_LOAD;
    req_bus.plane_index = '0;
    req_bus.vec_a_x     = '0;
    req_bus.vec_a_y     = '0;
    req_bus.vec_a_z     = '0;
    req_bus.vec_b_x     = '0;
    req_bus.vec_b_y     = '0;
    req_bus.vec_b_z     = '0;
    req_bus.scalar      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].chk, 1'b1);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (!pressure_done && sent >= 150) begin
        // results held back while requests keep coming, so the chain backs up
        pressure_done = 1'b1;
        hold_results  = 1'b1;
        repeat (24) issue(random_test(), FROM_MODEL, 1'b0);
      end
      if (!drain_done && sent >= 300) begin
        drain_done    = 1'b1;
        req_bus.valid <= 1'b0;
        while (visible_due.size() != 0) @(posedge clk_i);
        repeat (LATENCY) @(posedge clk_i);
      end
      tail      = (sent >= RAND_ITEMS - TAIL_ITEMS);
      bursts_on = !tail && ($urandom_range(0, 3) != 0);
      run_episode();
    end

    req_bus.valid <= 1'b0;
    while (visible_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
design/fsbc_pkg.sv
design/fsbc_if.sv
design/fsbc_cell.sv
design/frustum_sphere_box_cull_core.sv
design/fsbc_checker.sv
tb/frustum_sphere_box_cull_core_tb.sv
